>>> sv/udpf_pkg.sv
// ----------------------------------------------------------------------------
// udpf_pkg - shared types and constants of the UDP multicast frame filter
// Request layouts, configuration set and verdict codes.
// ----------------------------------------------------------------------------
package udpf_pkg;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } in_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        frame_done;
    logic [2:0]  verdict;
    logic [15:0] payload_length;
  } out_t;

  typedef struct packed {
    logic [15:0] match_port;
    logic [31:0] match_address;
  } cfg_t;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_MATCH_PORT    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MATCH_ADDRESS = 1'd1;

  localparam logic [15:0] MATCH_PORT_RESET    = 16'd44040;
  localparam logic [31:0] MATCH_ADDRESS_RESET = 32'hEFC3_1452;

  localparam logic [2:0] V_ACCEPT     = 3'd0;
  localparam logic [2:0] V_SHORT      = 3'd1;
  localparam logic [2:0] V_NOT_IPV4   = 3'd2;
  localparam logic [2:0] V_NOT_UDP    = 3'd3;
  localparam logic [2:0] V_MISMATCH   = 3'd4;
  localparam logic [2:0] V_BAD_LENGTH = 3'd5;
  localparam logic [2:0] V_TRUNCATED  = 3'd6;

  localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  IP_PROTO_UDP     = 8'd17;
  localparam logic [3:0]  MIN_IHL          = 4'd5;
  localparam logic [6:0]  ETH_HEADER_BYTES = 7'd14;
  localparam logic [15:0] UDP_HEADER_BYTES = 16'd8;
  localparam logic [16:0] MIN_FRAME_BYTES  = 17'd42;
  localparam logic [15:0] POS_ETHERTYPE_LO = 16'd13;
  localparam logic [15:0] POS_IHL          = 16'd14;
  localparam logic [15:0] POS_PROTOCOL     = 16'd23;
  localparam logic [15:0] POS_DEST_ADDR_LO = 16'd33;
  localparam logic [15:0] POS_MAX          = 16'hFFFF;

endpackage

>>> sv/udpf_parse.sv
// ----------------------------------------------------------------------------
// udpf_parse - per-frame header parser
// Holds the frame state, checks header fields byte by byte and builds the
// result for each accepted byte.
// ----------------------------------------------------------------------------
module udpf_parse (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  udpf_pkg::in_t  frame,
  input  udpf_pkg::cfg_t cfg,
  output udpf_pkg::out_t res,
  output logic           res_fire
);

  logic [15:0] byte_position;
  logic [3:0]  header_words;
  logic [31:0] field_shift;
  logic [15:0] udp_length_seen;
  logic [15:0] payload_remaining;
  logic [2:0]  running_verdict;

  logic [15:0] byte_position_next;
  logic [3:0]  header_words_next;
  logic [31:0] field_shift_next;
  logic [15:0] udp_length_seen_next;
  logic [15:0] payload_remaining_next;
  logic [2:0]  running_verdict_next;

  logic [15:0] low16;
  logic        hdr_ok;
  logic [15:0] udp_start;
  logic [16:0] udp_end_new;
  logic [16:0] count;
  logic        fwd;
  logic [2:0]  verdict;

  always_comb begin
    field_shift_next       = {field_shift[23:0], frame.frame_byte};
    low16                  = field_shift_next[15:0];
    hdr_ok                 = header_words >= udpf_pkg::MIN_IHL;
    udp_start              = {9'd0, udpf_pkg::ETH_HEADER_BYTES + {1'b0, header_words, 2'b00}};
    header_words_next      = header_words;
    running_verdict_next   = running_verdict;
    udp_length_seen_next   = udp_length_seen;
    payload_remaining_next = payload_remaining;
    fwd                    = 1'b0;

    if (byte_position == udpf_pkg::POS_ETHERTYPE_LO && low16 != udpf_pkg::ETHERTYPE_IPV4) begin
      if (running_verdict_next == udpf_pkg::V_ACCEPT) running_verdict_next = udpf_pkg::V_NOT_IPV4;
    end
    if (byte_position == udpf_pkg::POS_IHL) begin
      header_words_next = frame.frame_byte[3:0];
      if (frame.frame_byte[3:0] < udpf_pkg::MIN_IHL &&
          running_verdict_next == udpf_pkg::V_ACCEPT) begin
        running_verdict_next = udpf_pkg::V_BAD_LENGTH;
      end
    end
    if (byte_position == udpf_pkg::POS_PROTOCOL && frame.frame_byte != udpf_pkg::IP_PROTO_UDP) begin
      if (running_verdict_next == udpf_pkg::V_ACCEPT) running_verdict_next = udpf_pkg::V_NOT_UDP;
    end
    if (byte_position == udpf_pkg::POS_DEST_ADDR_LO && field_shift_next != cfg.match_address) begin
      if (running_verdict_next == udpf_pkg::V_ACCEPT) running_verdict_next = udpf_pkg::V_MISMATCH;
    end

    if (hdr_ok) begin
      if (byte_position == udp_start + 16'd3 && low16 != cfg.match_port) begin
        if (running_verdict_next == udpf_pkg::V_ACCEPT) running_verdict_next = udpf_pkg::V_MISMATCH;
      end
      if (byte_position == udp_start + 16'd5) begin
        udp_length_seen_next = low16;
        if (low16 < udpf_pkg::UDP_HEADER_BYTES) begin
          if (running_verdict_next == udpf_pkg::V_ACCEPT) begin
            running_verdict_next = udpf_pkg::V_BAD_LENGTH;
          end
          payload_remaining_next = 16'd0;
        end else begin
          payload_remaining_next = low16 - udpf_pkg::UDP_HEADER_BYTES;
        end
      end
      if (running_verdict_next == udpf_pkg::V_ACCEPT &&
          byte_position >= udp_start + udpf_pkg::UDP_HEADER_BYTES &&
          payload_remaining_next != 16'd0) begin
        fwd                    = 1'b1;
        payload_remaining_next = payload_remaining_next - 16'd1;
      end
    end

    byte_position_next = (byte_position != udpf_pkg::POS_MAX) ? byte_position + 16'd1
                                                              : byte_position;

    count       = {1'b0, byte_position} + 17'd1;
    udp_end_new = {10'd0, udpf_pkg::ETH_HEADER_BYTES + {1'b0, header_words_next, 2'b00}}
                  + {1'b0, udpf_pkg::UDP_HEADER_BYTES};
    if (count < udpf_pkg::MIN_FRAME_BYTES) begin
      verdict = udpf_pkg::V_SHORT;
    end else if (running_verdict_next != udpf_pkg::V_ACCEPT) begin
      verdict = running_verdict_next;
    end else if (header_words_next < udpf_pkg::MIN_IHL || count < udp_end_new) begin
      verdict = udpf_pkg::V_SHORT;
    end else if (payload_remaining_next != 16'd0) begin
      verdict = udpf_pkg::V_TRUNCATED;
    end else begin
      verdict = udpf_pkg::V_ACCEPT;
    end

    res.payload_byte   = fwd ? frame.frame_byte : 8'd0;
    res.payload_valid  = fwd;
    res.frame_done     = frame.end_of_frame;
    res.verdict        = frame.end_of_frame ? verdict : udpf_pkg::V_ACCEPT;
    res.payload_length = 16'd0;
    if (frame.end_of_frame &&
        (verdict == udpf_pkg::V_ACCEPT || verdict == udpf_pkg::V_TRUNCATED) &&
        udp_length_seen_next >= udpf_pkg::UDP_HEADER_BYTES) begin
      res.payload_length = udp_length_seen_next - udpf_pkg::UDP_HEADER_BYTES;
    end
    res_fire = fwd || frame.end_of_frame;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && frame.end_of_frame)) begin
      byte_position     <= 16'd0;
      header_words      <= 4'd0;
      field_shift       <= 32'd0;
      udp_length_seen   <= 16'd0;
      payload_remaining <= 16'd0;
      running_verdict   <= udpf_pkg::V_ACCEPT;
    end else if (take) begin
      byte_position     <= byte_position_next;
      header_words      <= header_words_next;
      field_shift       <= field_shift_next;
      udp_length_seen   <= udp_length_seen_next;
      payload_remaining <= payload_remaining_next;
      running_verdict   <= running_verdict_next;
    end
  end

endmodule

>>> sv/udpf_out_reg.sv
// ----------------------------------------------------------------------------
// udpf_out_reg - result register
// Holds one result request until the downstream side takes it.
// ----------------------------------------------------------------------------
module udpf_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  udpf_pkg::out_t load_data,
  input  logic           result_ready,
  output logic           result_valid,
  output udpf_pkg::out_t result
);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= load_data;
    end
  end

endmodule

>>> sv/udp_multicast_frame_filter_core.sv
// ----------------------------------------------------------------------------
// udp_multicast_frame_filter_core - Ethernet/IPv4/UDP destination filter
// Forwards the UDP payload of frames addressed to the configured group and
// port, and gives a verdict on the last byte of every frame.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------
//   frame    | frame_valid / frame_ready  | frame (in_t)
//   result   | result_valid / result_ready| result (out_t)
//   config   | cfg_we                     | cfg_index, cfg_data
//
// One byte is accepted per cycle while no result is stalled, a rate set by
// the single result register. Payload and last bytes load a registered result.
// Reset clears frame state, loads the default port and address.
// A stalled result holds the frame side only while it is still waiting.
// ----------------------------------------------------------------------------
module udp_multicast_frame_filter_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             frame_valid,
  output logic                             frame_ready,
  input  udpf_pkg::in_t                    frame,
  output logic                             result_valid,
  input  logic                             result_ready,
  output udpf_pkg::out_t                   result,
  input  logic                             cfg_we,
  input  logic [udpf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [udpf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  udpf_pkg::cfg_t cfg;
  udpf_pkg::out_t res;
  logic           res_fire;
  logic           take;

  assign frame_ready = !result_valid || result_ready;
  assign take        = frame_valid && frame_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_port    <= udpf_pkg::MATCH_PORT_RESET;
      cfg.match_address <= udpf_pkg::MATCH_ADDRESS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        udpf_pkg::REG_MATCH_PORT: begin
          cfg.match_port <= cfg_data[15:0];
        end
        udpf_pkg::REG_MATCH_ADDRESS: begin
          cfg.match_address <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  udpf_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .frame    (frame),
    .cfg      (cfg),
    .res      (res),
    .res_fire (res_fire)
  );

  udpf_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (take && res_fire),
    .load_data    (res),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

>>> tb/udpf_checker.sv
// ----------------------------------------------------------------------------
// udpf_checker - result predictor and scoreboard for the frame filter
// Watches the frame, result and config ports of the filter core, tracks the
// header parse of each frame byte and compares every result request with
// the oldest predicted one. Hands mismatch and progress counts to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module udpf_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             frame_valid,
  input  logic                             frame_ready,
  input  udpf_pkg::in_t                    frame,
  input  logic                             result_valid,
  input  logic                             result_ready,
  input  udpf_pkg::out_t                   result,
  input  logic                             cfg_we,
  input  logic [udpf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [udpf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               mismatch_count,
  output int                               results_pending,
  output int                               frames_checked,
  output int                               frames_accepted,
  output int                               payload_bytes_seen
);

  logic [15:0] port_sel;
  logic [31:0] addr_sel;
  logic [15:0] byte_pos;
  logic [3:0]  hdr_words;
  logic [31:0] shift_reg;
  logic [15:0] udp_len;
  logic [15:0] remaining;
  logic [2:0]  first_fail;

  udpf_pkg::out_t awaited_results[$];
  int   n_bad;
  int   n_frames;
  int   n_accepted;
  int   n_payload;

  task automatic clear_frame();
    byte_pos   = '0;
    hdr_words  = '0;
    shift_reg  = '0;
    udp_len    = '0;
    remaining  = '0;
    first_fail = udpf_pkg::V_ACCEPT;
  endtask

  task automatic note_failure(input logic [2:0] code);
    if (first_fail == udpf_pkg::V_ACCEPT) first_fail = code;
  endtask

  task automatic track_frame_byte(input logic [7:0] b, input logic last);
    logic [15:0]    low16;
    int             pos;
    int             udp;
    int             count;
    bit             fwd;
    bit             hdr_ok;
    logic [2:0]     v;
    udpf_pkg::out_t r;
    pos    = int'(byte_pos);
    hdr_ok = hdr_words >= udpf_pkg::MIN_IHL;
    udp    = int'(udpf_pkg::ETH_HEADER_BYTES) + 4 * int'(hdr_words);
    fwd    = 1'b0;
    shift_reg = {shift_reg[23:0], b};
    low16     = shift_reg[15:0];

    if (pos == int'(udpf_pkg::POS_ETHERTYPE_LO) && low16 != udpf_pkg::ETHERTYPE_IPV4)
      note_failure(udpf_pkg::V_NOT_IPV4);
    if (pos == int'(udpf_pkg::POS_IHL)) begin
      hdr_words = b[3:0];
      if (hdr_words < udpf_pkg::MIN_IHL) note_failure(udpf_pkg::V_BAD_LENGTH);
    end
    if (pos == int'(udpf_pkg::POS_PROTOCOL) && b != udpf_pkg::IP_PROTO_UDP)
      note_failure(udpf_pkg::V_NOT_UDP);
    if (pos == int'(udpf_pkg::POS_DEST_ADDR_LO) && shift_reg != addr_sel)
      note_failure(udpf_pkg::V_MISMATCH);

    if (hdr_ok) begin
      if (pos == udp + 3 && low16 != port_sel) note_failure(udpf_pkg::V_MISMATCH);
      if (pos == udp + 5) begin
        udp_len = low16;
        if (low16 < udpf_pkg::UDP_HEADER_BYTES) begin
          note_failure(udpf_pkg::V_BAD_LENGTH);
          remaining = '0;
        end else begin
          remaining = low16 - udpf_pkg::UDP_HEADER_BYTES;
        end
      end
      if (first_fail == udpf_pkg::V_ACCEPT &&
          pos >= udp + int'(udpf_pkg::UDP_HEADER_BYTES) && remaining != 0) begin
        fwd       = 1'b1;
        remaining = remaining - 16'd1;
      end
    end

    if (byte_pos != udpf_pkg::POS_MAX) byte_pos = byte_pos + 16'd1;

    if (fwd || last) begin
      r = '0;
      r.payload_byte  = fwd ? b : 8'd0;
      r.payload_valid = fwd;
      r.frame_done    = last;
      if (fwd) n_payload++;
      if (last) begin
        count = pos + 1;
        if (count < int'(udpf_pkg::MIN_FRAME_BYTES)) v = udpf_pkg::V_SHORT;
        else if (first_fail != udpf_pkg::V_ACCEPT) v = first_fail;
        else if (hdr_words < udpf_pkg::MIN_IHL ||
                 count < int'(udpf_pkg::ETH_HEADER_BYTES) + 4 * int'(hdr_words) +
                         int'(udpf_pkg::UDP_HEADER_BYTES))
          v = udpf_pkg::V_SHORT;
        else if (remaining != 0) v = udpf_pkg::V_TRUNCATED;
        else v = udpf_pkg::V_ACCEPT;
        r.verdict = v;
        if ((v == udpf_pkg::V_ACCEPT || v == udpf_pkg::V_TRUNCATED) &&
            udp_len >= udpf_pkg::UDP_HEADER_BYTES)
          r.payload_length = udp_len - udpf_pkg::UDP_HEADER_BYTES;
        n_frames++;
        if (v == udpf_pkg::V_ACCEPT) n_accepted++;
        clear_frame();
      end
      awaited_results.push_back(r);
    end
  endtask

  initial begin
    n_bad      = 0;
    n_frames   = 0;
    n_accepted = 0;
    n_payload  = 0;
    port_sel   = udpf_pkg::MATCH_PORT_RESET;
    addr_sel   = udpf_pkg::MATCH_ADDRESS_RESET;
    clear_frame();
    mismatch_count     = 0;
    results_pending    = 0;
    frames_checked     = 0;
    frames_accepted    = 0;
    payload_bytes_seen = 0;
  end

  always @(posedge clk) begin
    udpf_pkg::out_t exp_r;
    if (rst) begin
      port_sel = udpf_pkg::MATCH_PORT_RESET;
      addr_sel = udpf_pkg::MATCH_ADDRESS_RESET;
      clear_frame();
      awaited_results.delete();
    end else begin
      // result first: it belongs to a byte taken at an earlier edge
      if (result_valid && result_ready) begin
        if (awaited_results.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected result request: byte=%h valid=%b done=%b verdict=%0d len=%0d",
                     result.payload_byte, result.payload_valid, result.frame_done,
                     result.verdict, result.payload_length);
        end else begin
          exp_r = awaited_results.pop_front();
          if (result.payload_byte !== exp_r.payload_byte ||
              result.payload_valid !== exp_r.payload_valid ||
              result.frame_done !== exp_r.frame_done ||
              result.verdict !== exp_r.verdict ||
              result.payload_length !== exp_r.payload_length) begin
            n_bad++;
            if (n_bad <= 10)
              $display({"result mismatch: expected byte=%h valid=%b done=%b verdict=%0d len=%0d,",
                        " got byte=%h valid=%b done=%b verdict=%0d len=%0d"},
                       exp_r.payload_byte, exp_r.payload_valid, exp_r.frame_done,
                       exp_r.verdict, exp_r.payload_length,
                       result.payload_byte, result.payload_valid, result.frame_done,
                       result.verdict, result.payload_length);
          end
        end
      end
      if (frame_valid && frame_ready) track_frame_byte(frame.frame_byte, frame.end_of_frame);
      if (cfg_we) begin
        case (cfg_index)
          udpf_pkg::REG_MATCH_PORT:    port_sel = cfg_data[15:0];
          udpf_pkg::REG_MATCH_ADDRESS: addr_sel = cfg_data;
          default: ;
        endcase
      end
    end
    mismatch_count     <= n_bad;
    results_pending    <= awaited_results.size();
    frames_checked     <= n_frames;
    frames_accepted    <= n_accepted;
    payload_bytes_seen <= n_payload;
  end

endmodule

>>> tb/tb_udp_multicast_frame_filter_core.sv
// ----------------------------------------------------------------------------
// tb_udp_multicast_frame_filter_core - testbench of the UDP frame filter
// Streams directed and random Ethernet frames (well-formed, padded, cut off,
// malformed and noise) through the filter under several port/address
// settings, with random stalls on both channels; the checker scores results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_udp_multicast_frame_filter_core;

  typedef enum int {
    DEF_ETHERTYPE,
    DEF_PROTOCOL,
    DEF_ADDRESS,
    DEF_PORT,
    DEF_IHL,
    DEF_UDP_LENGTH
  } defect_t;

  logic                             clk;
  logic                             rst;
  logic                             frame_valid;
  logic                             frame_ready;
  udpf_pkg::in_t                    frame;
  logic                             result_valid;
  logic                             result_ready;
  udpf_pkg::out_t                   result;
  logic                             cfg_we;
  logic [udpf_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [udpf_pkg::CFG_DATA_W-1:0]  cfg_data;

  int mismatch_count;
  int results_pending;
  int frames_checked;
  int frames_accepted;
  int payload_bytes_seen;

  logic [7:0]  frame_bytes[$];
  logic [15:0] cur_port;
  logic [31:0] cur_addr;
  bit          idling_on;
  int          stall_left;
  int          bytes_sent;
  int          settings_used;

  udp_multicast_frame_filter_core uut (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame        (frame),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  udpf_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .frame_valid        (frame_valid),
    .frame_ready        (frame_ready),
    .frame              (frame),
    .result_valid       (result_valid),
    .result_ready       (result_ready),
    .result             (result),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatch_count     (mismatch_count),
    .results_pending    (results_pending),
    .frames_checked     (frames_checked),
    .frames_accepted    (frames_accepted),
    .payload_bytes_seen (payload_bytes_seen)
  );

  always #4 clk = ~clk;

  // stall the result side in random bursts while idling is on
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 15);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  task automatic send_frame();
    int gap;
    for (int i = 0; i < frame_bytes.size(); i++) begin
      if (idling_on && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 16);
        @(negedge clk);
        frame_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      frame_valid <= 1'b1;
      frame       <= {frame_bytes[i], i == frame_bytes.size() - 1};
      do @(posedge clk); while (!frame_ready);
      bytes_sent++;
    end
  endtask

  task automatic emit_frame(input logic [15:0] ethertype, input logic [3:0] ihl,
                            input logic [7:0] proto, input logic [31:0] daddr,
                            input logic [15:0] dport, input logic [15:0] ulen,
                            input int payload_n, input int pad_n, input int cut_len);
    logic [7:0] rb;
    frame_bytes.delete();
    repeat (12) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(ethertype[15:8]);
    frame_bytes.push_back(ethertype[7:0]);
    rb = $urandom;
    frame_bytes.push_back({rb[7:4], ihl});
    repeat (8) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(proto);
    repeat (6) frame_bytes.push_back(8'($urandom));
    for (int k = 3; k >= 0; k--) frame_bytes.push_back(daddr[8*k +: 8]);
    if (ihl > udpf_pkg::MIN_IHL)
      repeat (4 * (int'(ihl) - 5)) frame_bytes.push_back(8'($urandom));
    repeat (2) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(dport[15:8]);
    frame_bytes.push_back(dport[7:0]);
    frame_bytes.push_back(ulen[15:8]);
    frame_bytes.push_back(ulen[7:0]);
    repeat (2) frame_bytes.push_back(8'($urandom));
    repeat (payload_n) frame_bytes.push_back(8'($urandom));
    repeat (pad_n) frame_bytes.push_back(8'($urandom));
    if (cut_len > 0) while (frame_bytes.size() > cut_len) void'(frame_bytes.pop_back());
    send_frame();
  endtask

  task automatic fill_frame(input logic [7:0] value, input int len);
    frame_bytes.delete();
    repeat (len) frame_bytes.push_back(value);
    send_frame();
  endtask

  task automatic settle();
    @(negedge clk);
    frame_valid <= 1'b0;
    wait (results_pending == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_settings(input logic [15:0] port, input logic [31:0] addr);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= udpf_pkg::REG_MATCH_PORT;
    cfg_data  <= {16'd0, port};
    @(negedge clk);
    cfg_index <= udpf_pkg::REG_MATCH_ADDRESS;
    cfg_data  <= addr;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_port = port;
    cur_addr = addr;
    settings_used++;
  endtask

  task automatic random_frame();
    int          roll;
    int          n;
    int          pad;
    int          cut;
    logic [3:0]  ihl;
    logic [15:0] et;
    logic [15:0] port;
    logic [15:0] ulen;
    logic [7:0]  proto;
    logic [31:0] addr;
    defect_t     d;
    roll  = $urandom_range(0, 99);
    ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : udpf_pkg::MIN_IHL;
    n     = $urandom_range(0, 24);
    pad   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
    cut   = 0;
    et    = udpf_pkg::ETHERTYPE_IPV4;
    proto = udpf_pkg::IP_PROTO_UDP;
    addr  = cur_addr;
    port  = cur_port;
    ulen  = 16'(n + 8);
    if (roll >= 97) begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 80)) frame_bytes.push_back(8'($urandom));
      send_frame();
      return;
    end else if (roll >= 72) begin
      repeat ($urandom_range(1, 2)) begin
        d = defect_t'($urandom_range(0, 5));
        case (d)
          DEF_ETHERTYPE:  et    = et ^ 16'($urandom_range(1, 16'hFFFF));
          DEF_PROTOCOL:   proto = proto ^ 8'($urandom_range(1, 255));
          DEF_ADDRESS:    addr  = addr ^ (32'h1 << $urandom_range(0, 31));
          DEF_PORT:       port  = port ^ (16'h1 << $urandom_range(0, 15));
          DEF_IHL:        ihl   = 4'($urandom_range(0, 4));
          DEF_UDP_LENGTH: ulen  = 16'($urandom_range(0, 7));
          default: ;
        endcase
      end
    end else if (roll >= 67) begin
      cut = $urandom_range(1, 41);
    end else if (roll >= 62) begin
      ihl = 4'($urandom_range(6, 15));
      cut = $urandom_range(42, 14 + 4 * int'(ihl) + 7);
    end else if (roll >= 55) begin
      n    = $urandom_range(1, 24);
      ulen = 16'(n + 8);
      pad  = 0;
      cut  = 14 + 4 * int'(ihl) + 8 + $urandom_range(0, n - 1);
    end
    emit_frame(et, ihl, proto, addr, port, ulen, n, pad, cut);
  endtask

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    frame_valid   = 1'b0;
    frame         = '0;
    result_ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    idling_on     = 1'b1;
    stall_left    = 0;
    bytes_sent    = 0;
    settings_used = 1;
    cur_port      = udpf_pkg::MATCH_PORT_RESET;
    cur_addr      = udpf_pkg::MATCH_ADDRESS_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed frames on the reset settings
    emit_frame(udpf_pkg::ETHERTYPE_IPV4, 4'd5, udpf_pkg::IP_PROTO_UDP, cur_addr, cur_port,
               16'd8, 0, 0, 0);
    emit_frame(udpf_pkg::ETHERTYPE_IPV4, 4'd5, udpf_pkg::IP_PROTO_UDP, cur_addr, cur_port,
               16'd14, 6, 0, 0);
    emit_frame(udpf_pkg::ETHERTYPE_IPV4, 4'd15, udpf_pkg::IP_PROTO_UDP, cur_addr, cur_port,
               16'd11, 3, 0, 0);
    emit_frame(udpf_pkg::ETHERTYPE_IPV4, 4'd5, udpf_pkg::IP_PROTO_UDP, cur_addr, cur_port,
               16'd12, 4, 5, 0);
    emit_frame(udpf_pkg::ETHERTYPE_IPV4, 4'd5, udpf_pkg::IP_PROTO_UDP, cur_addr, cur_port,
               16'd18, 10, 0, 46);
    emit_frame(udpf_pkg::ETHERTYPE_IPV4, 4'd6, udpf_pkg::IP_PROTO_UDP, cur_addr, cur_port,
               16'd10, 2, 0, 44);
    emit_frame(udpf_pkg::ETHERTYPE_IPV4, 4'd5, udpf_pkg::IP_PROTO_UDP, cur_addr, cur_port,
               16'd8, 0, 0, 41);
    emit_frame(udpf_pkg::ETHERTYPE_IPV4, 4'd5, udpf_pkg::IP_PROTO_UDP, cur_addr, cur_port,
               16'd8, 0, 0, 20);
    emit_frame(udpf_pkg::ETHERTYPE_IPV4, 4'd5, udpf_pkg::IP_PROTO_UDP, cur_addr, cur_port,
               16'd8, 0, 0, 1);
    emit_frame(16'h86DD, 4'd5, udpf_pkg::IP_PROTO_UDP, cur_addr, cur_port,
               16'd12, 4, 0, 0);
    emit_frame(udpf_pkg::ETHERTYPE_IPV4, 4'd5, 8'd6, cur_addr, cur_port,
               16'd12, 4, 0, 0);
    emit_frame(udpf_pkg::ETHERTYPE_IPV4, 4'd5, udpf_pkg::IP_PROTO_UDP, cur_addr ^ 32'h1,
               cur_port, 16'd12, 4, 0, 0);
    emit_frame(udpf_pkg::ETHERTYPE_IPV4, 4'd5, udpf_pkg::IP_PROTO_UDP, cur_addr,
               cur_port ^ 16'h8000, 16'd12, 4, 0, 0);
    emit_frame(udpf_pkg::ETHERTYPE_IPV4, 4'd0, udpf_pkg::IP_PROTO_UDP, cur_addr, cur_port,
               16'd12, 4, 0, 0);
    emit_frame(udpf_pkg::ETHERTYPE_IPV4, 4'd4, udpf_pkg::IP_PROTO_UDP, cur_addr, cur_port,
               16'd12, 4, 0, 0);
    emit_frame(udpf_pkg::ETHERTYPE_IPV4, 4'd5, udpf_pkg::IP_PROTO_UDP, cur_addr, cur_port,
               16'd0, 4, 0, 0);
    emit_frame(udpf_pkg::ETHERTYPE_IPV4, 4'd5, udpf_pkg::IP_PROTO_UDP, cur_addr, cur_port,
               16'd7, 4, 0, 0);
    emit_frame(16'h0806, 4'd5, 8'd1, cur_addr, cur_port, 16'd12, 4, 0, 0);
    emit_frame(udpf_pkg::ETHERTYPE_IPV4, 4'd5, udpf_pkg::IP_PROTO_UDP, ~cur_addr, cur_port,
               16'd3, 4, 0, 0);
    fill_frame(8'hFF, 60);
    fill_frame(8'h00, 60);

    // extreme settings
    settle();
    write_settings(16'h0000, 32'h0000_0000);
    emit_frame(udpf_pkg::ETHERTYPE_IPV4, 4'd5, udpf_pkg::IP_PROTO_UDP, cur_addr, cur_port,
               16'd13, 5, 0, 0);
    emit_frame(udpf_pkg::ETHERTYPE_IPV4, 4'd5, udpf_pkg::IP_PROTO_UDP, cur_addr, 16'h0001,
               16'd13, 5, 0, 0);
    settle();
    write_settings(16'hFFFF, 32'hFFFF_FFFF);
    emit_frame(udpf_pkg::ETHERTYPE_IPV4, 4'd7, udpf_pkg::IP_PROTO_UDP, cur_addr, cur_port,
               16'd13, 5, 2, 0);

    // random phases, the last one without idling
    for (int phase = 0; phase < 4; phase++) begin
      int target;
      settle();
      case (phase)
        1:       write_settings(16'h0000, 32'($urandom));
        2:       write_settings(16'($urandom), 32'hFFFF_FFFF);
        default: write_settings(16'($urandom), 32'($urandom));
      endcase
      idling_on = (phase != 3);
      target = bytes_sent + 220;
      while (bytes_sent < target) random_frame();
    end

    settle();
    repeat (8) @(posedge clk);
    $display("covered %0d frames (%0d accepted), %0d forwarded payload bytes, %0d input bytes",
             frames_checked, frames_accepted, payload_bytes_seen, bytes_sent);
    $display("under %0d port/address settings, including all-zero and all-one values",
             settings_used);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatching result requests", mismatch_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> udp_multicast_frame_filter_core.f
sv/udpf_pkg.sv
sv/udpf_parse.sv
sv/udpf_out_reg.sv
sv/udp_multicast_frame_filter_core.sv
tb/udpf_checker.sv
tb/tb_udp_multicast_frame_filter_core.sv
